// ----- sv/b2da_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg - shared types and constants for the decimal text converter
// widths, digit record carried from front to back, divide-by-ten constants
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int ValueW     = 16;
  localparam int DigitW     = 4;
  localparam int DigitsMax  = 5;
  localparam int IdxW       = $clog2(DigitsMax);
  localparam int CountW     = $clog2(DigitsMax + 1);
  localparam int CharW      = 6;

  // ascii '0'; digits 0..9 map to 48..57
  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  // floor(v / 10) == (v * 52429) >> 19, exact for every 16-bit v
  localparam int RecipW = 17;
  localparam logic [RecipW-1:0] RecipTen = 17'd52429;
  localparam int RecipShift = 19;

  localparam int DefQueueDepth = 2;

  // one converted number: digits least significant first, count of valid digits
  typedef struct packed {
    logic [DigitsMax-1:0][DigitW-1:0] digits;
    logic [CountW-1:0]                count;
  } dec_rec_t;

endpackage

// ----- sv/b2da_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_front - input side of the converter
// takes a number and peels off one decimal digit per cycle by reciprocal divide
// ----------------------------------------------------------------------------
module b2da_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [b2da_pkg::ValueW-1:0] value,
  input  logic                     push,
  output logic                     full,
  output b2da_pkg::dec_rec_t       rec,
  output logic                     rec_push,
  input  logic                     rec_full
);
  import b2da_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0]                       state;
  logic [ValueW-1:0]                work;
  logic [CountW-1:0]                cnt;
  logic [DigitsMax-1:0][DigitW-1:0] digits;

  logic [ValueW+RecipW-1:0] prod;
  logic [ValueW-1:0]        quo;
  logic [ValueW+3:0]        quo_ten;
  logic [ValueW+3:0]        rem_full;
  logic [DigitW-1:0]        rem;
  logic                     take;

  always_comb begin
    prod     = {{RecipW{1'b0}}, work} * {{ValueW{1'b0}}, RecipTen};
    quo      = ValueW'(prod >> RecipShift);
    quo_ten  = ({4'd0, quo} << 3) + ({4'd0, quo} << 1);
    rem_full = {4'd0, work} - quo_ten;
    rem      = rem_full[DigitW-1:0];
  end

  assign full     = (state == StConv) || ((state == StHold) && rec_full);
  assign take     = push && !full;
  assign rec_push = (state == StHold) && !rec_full;
  assign rec.digits = digits;
  assign rec.count  = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt   <= '0;
    end else begin
      unique case (state)
        StIdle: begin
          if (take) begin
            state <= StConv;
            cnt   <= '0;
          end
        end
        StConv: begin
          cnt <= cnt + CountW'(1);
          if (quo == '0) begin
            state <= StHold;
          end
        end
        StHold: begin
          if (rec_push) begin
            if (take) begin
              state <= StConv;
              cnt   <= '0;
            end else begin
              state <= StIdle;
            end
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (take) begin
      work <= value;
    end else if (state == StConv) begin
      work <= quo;
      digits[cnt[IdxW-1:0]] <= rem;
    end
  end

endmodule

// ----- sv/b2da_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_queue - small queue of digit records between front and back
// lets the front start the next number while the back is still emitting
// ----------------------------------------------------------------------------
module b2da_queue #(
  parameter int Depth = b2da_pkg::DefQueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  b2da_pkg::dec_rec_t wr_data,
  input  logic               wr_en,
  output logic               q_full,
  output b2da_pkg::dec_rec_t rd_data,
  output logic               rd_valid,
  input  logic               rd_en
);
  import b2da_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dec_rec_t          mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   fill;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign q_full   = (fill == CntW'(Depth));
  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CntW'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- sv/b2da_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_back - output side of the converter
// walks a digit record from the top digit down into the output register
// ----------------------------------------------------------------------------
module b2da_back (
  input  logic                       clk,
  input  logic                       rst,
  input  b2da_pkg::dec_rec_t         rd_data,
  input  logic                       rd_valid,
  output logic                       rd_en,
  output logic [b2da_pkg::CharW-1:0] digit_char,
  output logic                       last_digit,
  output logic                       empty,
  input  logic                       pop
);
  import b2da_pkg::*;

  dec_rec_t          cur;
  logic              active;
  logic [IdxW-1:0]   idx;
  logic              out_valid;
  logic              load_ok;
  logic              emit;
  logic              emit_last;

  assign empty     = !out_valid;
  assign load_ok   = !out_valid || pop;
  assign emit      = active && load_ok;
  assign emit_last = emit && (idx == '0);
  // fetch the next record while the final digit of the current one goes out
  assign rd_en     = rd_valid && (!active || emit_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        active <= 1'b1;
      end else if (emit_last) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur <= rd_data;
      idx <= IdxW'(rd_data.count - CountW'(1));
    end else if (emit) begin
      idx <= idx - IdxW'(1);
    end
    if (emit) begin
      digit_char <= AsciiZero + {{(CharW-DigitW){1'b0}}, cur.digits[idx]};
      last_digit <= (idx == '0);
    end
  end

endmodule

// ----- sv/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii - 16-bit unsigned number to decimal ascii digits
// emits the digits most significant first, no leading zeros, last flag on the
// final digit; zero gives a single '0'
// ----------------------------------------------------------------------------
//
//   channel   handshake        word
//   -------   --------------   ---------------------------------------
//   input     push / full      value[15:0]
//   result    empty / pop      digit_char[5:0], last_digit
//
// the front converts a number digit by digit (1..5 digits), using the
// single reciprocal divide-by-ten unit, then hands the record to the queue
// from its hold state, overlapped with taking the next number
// the back sends one digit per cycle from its output register while pop is
// held high and records are waiting
// rst is synchronous and clears the front state, the queue and the output
// valid flag; a stalled result side fills the queue and then raises full
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
  parameter int QueueDepth = b2da_pkg::DefQueueDepth
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [b2da_pkg::ValueW-1:0] value,
  input  logic                        push,
  output logic                        full,
  output logic [b2da_pkg::CharW-1:0]  digit_char,
  output logic                        last_digit,
  output logic                        empty,
  input  logic                        pop
);
  import b2da_pkg::*;

  // front to queue
  dec_rec_t fq_rec;
  logic     fq_push;
  logic     fq_full;

  // queue to back
  dec_rec_t qb_rec;
  logic     qb_valid;
  logic     qb_pop;

  // digit extraction, least significant first
  b2da_front u_front (
    .clk      (clk),
    .rst      (rst),
    .value    (value),
    .push     (push),
    .full     (full),
    .rec      (fq_rec),
    .rec_push (fq_push),
    .rec_full (fq_full)
  );

  // decouples conversion from the result side
  b2da_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (fq_rec),
    .wr_en    (fq_push),
    .q_full   (fq_full),
    .rd_data  (qb_rec),
    .rd_valid (qb_valid),
    .rd_en    (qb_pop)
  );

  // digit emission, most significant first
  b2da_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_data    (qb_rec),
    .rd_valid   (qb_valid),
    .rd_en      (qb_pop),
    .digit_char (digit_char),
    .last_digit (last_digit),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// ----- test/binary_to_decimal_ascii_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_test - self-checking bench for the decimal text converter
// pushes directed and random 16-bit numbers, predicts the ascii digit words
// of each, and checks every popped word in order, with random stalls
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_test;
  import b2da_pkg::*;

  localparam int ClkHalf     = 4;
  localparam int RandomCount = 400;
  localparam int CalmTail    = 60;   // last random numbers run with no idling
  localparam int PauseAt     = 200;  // sender drains the block here once
  localparam int WatchLimit  = 2000; // cycles with no word moving on either side
  localparam int TailCycles  = 20;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } digit_word_t;

  // holds the digit words still owed by the block, oldest first
  class digit_ledger;
    digit_word_t owed[$];
    int unsigned mismatches = 0;

    // split one accepted number into its decimal digits, most significant first
    function void note_value(logic [ValueW-1:0] v);
      int unsigned rest;
      int unsigned rev[$];
      digit_word_t w;
      rest = v;
      do begin
        rev.push_back(rest % 10);
        rest = rest / 10;
      end while (rest != 0);
      for (int k = rev.size() - 1; k >= 0; k--) begin
        w.ch   = AsciiZero + CharW'(rev[k]);
        w.last = (k == 0);
        owed.push_back(w);
      end
    endfunction

    function void check_digit(logic [CharW-1:0] ch, logic last);
      digit_word_t w;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word char=%0d last=%0b", $realtime, ch, last);
        return;
      end
      w = owed.pop_front();
      if (ch !== w.ch || last !== w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: word mismatch exp char=%0d last=%0b got char=%0d last=%0b",
                   $realtime, w.ch, w.last, ch, last);
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [ValueW-1:0] value = '0;
  logic              push = 1'b0;
  logic              full;
  logic [CharW-1:0]  digit_char;
  logic              last_digit;
  logic              empty;
  logic              pop = 1'b0;

  // set for the final stretch: neither side idles any more
  logic calm = 1'b0;

  digit_ledger ledger = new;

  binary_to_decimal_ascii u_dut (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .push       (push),
    .full       (full),
    .digit_char (digit_char),
    .last_digit (last_digit),
    .empty      (empty),
    .pop        (pop)
  );

  initial begin
    forever #(ClkHalf) clk = ~clk;
  end

  // present one number at the falling edge and hold it until a rising edge
  // sees full low; push stays high so back-to-back numbers need no gap
  task automatic send_value(logic [ValueW-1:0] v);
    @(negedge clk);
    value <= v;
    push  <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      push  <= 1'b0;
      value <= ValueW'($urandom);
    end
  endtask

  // pick a number whose decimal length is drawn evenly from 1 to 5 digits,
  // with a share of plain 16-bit noise and exact length boundaries
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned len;
    len = $urandom_range(0, 6);
    case (len)
      0: return 16'($urandom_range(0, 9));
      1: return 16'($urandom_range(10, 99));
      2: return 16'($urandom_range(100, 999));
      3: return 16'($urandom_range(1000, 9999));
      4: return 16'($urandom_range(10000, 65535));
      5: begin
        // just below or at a power of ten, or at the top of the range
        case ($urandom_range(0, 4))
          0: return 16'd9 + 16'($urandom_range(0, 1));
          1: return 16'd99 + 16'($urandom_range(0, 1));
          2: return 16'd999 + 16'($urandom_range(0, 1));
          3: return 16'd9999 + 16'($urandom_range(0, 1));
          default: return 16'hFFFF - 16'($urandom_range(0, 3));
        endcase
      end
      default: return ValueW'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [ValueW-1:0] directed[$];
    directed = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
                 16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'd32768, 16'd12345,
                 16'd54321, 16'd10001, 16'd50000, 16'd60000, 16'hAAAA, 16'h5555,
                 16'd90, 16'd0, 16'd7, 16'd40960};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero, each digit count, length boundaries, all-ones, bit patterns
    foreach (directed[i]) begin
      if (i == 12) idle_input(3);
      send_value(directed[i]);
    end

    for (int n = 0; n < RandomCount; n++) begin
      if (n == RandomCount - CalmTail) calm <= 1'b1;
      if (n == PauseAt) begin
        // hold off the sender until the block has handed over everything owed
        idle_input(1);
        while (ledger.pending() != 0) @(posedge clk);
      end
      if (n < RandomCount - CalmTail && $urandom_range(0, 5) == 0)
        idle_input($urandom_range(1, 11));
      send_value(pick_value());
    end
    idle_input(1);

    while (ledger.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("binary_to_decimal_ascii_test: done, clean");
    end else begin
      $display("binary_to_decimal_ascii_test: done, errors");
    end
    $finish;
  end

  // result side: pop changes at the falling edge, stalls come in random bursts,
  // with stretches that run without any stall
  initial begin
    int stall_left;
    int span_left;
    bit stall_span;
    stall_left = 0;
    span_left  = 0;
    stall_span = 1'b1;
    forever begin
      @(negedge clk);
      if (span_left == 0) begin
        span_left  = 64;
        stall_span = ($urandom_range(0, 2) != 0);
      end
      span_left--;
      if (rst) begin
        pop <= 1'b0;
      end else if (calm || !stall_span) begin
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // monitor: note accepted numbers and check popped words at the rising edge,
  // and stop the run if nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        quiet++;
        if (push && !full) begin
          ledger.note_value(value);
          quiet = 0;
        end
        if (pop && !empty) begin
          ledger.check_digit(digit_char, last_digit);
          quiet = 0;
        end
        if (quiet >= WatchLimit) begin
          $display("%0t: watchdog, no word moved for %0d cycles", $realtime, quiet);
          $display("binary_to_decimal_ascii_test: done, errors");
          $finish;
        end
      end
    end
  end

endmodule
